FILE: hdl/wep_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wep_pkg
// Shared types, constants and functions for the WEP RC4 decryptor with
// CRC-32 integrity check.
// ----------------------------------------------------------------------------
package wep_pkg;

   // Number of seed bytes held for the key schedule (IV plus key).
   localparam int SEED_BYTES  = 16;
   localparam int SEED_AW     = $clog2(SEED_BYTES);
   localparam int SEED_CNT_W  = $clog2(SEED_BYTES + 1);

   // Number of integrity check bytes in a frame.
   localparam logic [2:0] ICV_LEN = 3'd4;

   // Reflected CRC-32 polynomial and preset.
   localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
   localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;

   // Input command codes.
   localparam logic [1:0] CMD_SEED = 2'd0;
   localparam logic [1:0] CMD_DATA = 2'd1;
   localparam logic [1:0] CMD_ICV  = 2'd2;

   // Result kinds.
   localparam logic KIND_PLAIN   = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // Datapath operation codes issued by the controller.
   localparam logic [3:0] OP_NONE       = 4'd0;
   localparam logic [3:0] OP_IDLE       = 4'd1;
   localparam logic [3:0] OP_SEED       = 4'd2;
   localparam logic [3:0] OP_SEED_LAST  = 4'd3;
   localparam logic [3:0] OP_FILL       = 4'd4;
   localparam logic [3:0] OP_KSA_RD_A   = 4'd5;
   localparam logic [3:0] OP_KSA_RD_B   = 4'd6;
   localparam logic [3:0] OP_KSA_WR_A   = 4'd7;
   localparam logic [3:0] OP_KSA_WR_B   = 4'd8;
   localparam logic [3:0] OP_BYTE_START = 4'd9;
   localparam logic [3:0] OP_PRGA_RD_J  = 4'd10;
   localparam logic [3:0] OP_PRGA_RD_T  = 4'd11;
   localparam logic [3:0] OP_PRGA_FIN   = 4'd12;

   // Command from controller to datapath.
   typedef struct packed {
      logic [3:0] op;
   } ctl_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic cnt_max;   // sweep counter at its final entry
      logic out_free;  // result register can take a new result
   } dp_status_type;

   // One byte of the reflected CRC-32, bit by bit.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] v);
      logic [31:0] c;
      c = crc ^ {24'd0, v};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/wep_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wep_ctrl
// Controller: sequences the permutation fill, the key schedule and the
// per-byte keystream steps, and issues one datapath operation per cycle.
// ----------------------------------------------------------------------------
module wep_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic [1:0]             req_command,
   input  wire logic                   req_last,
   output logic                        req_tready,
   input  wire wep_pkg::dp_status_type status,
   output wep_pkg::ctl_cmd_type        cmd
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_FILL = 4'd1;
   localparam logic [3:0] ST_KRA  = 4'd2;
   localparam logic [3:0] ST_KRB  = 4'd3;
   localparam logic [3:0] ST_KWA  = 4'd4;
   localparam logic [3:0] ST_KWB  = 4'd5;
   localparam logic [3:0] ST_PRJ  = 4'd6;
   localparam logic [3:0] ST_PRT  = 4'd7;
   localparam logic [3:0] ST_PFIN = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Next state and operation for the datapath.
   always_comb begin
      state_in = state_ff;
      cmd.op   = wep_pkg::OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.op = wep_pkg::OP_IDLE;
            if (accept) begin
               case (req_command)
                  wep_pkg::CMD_SEED: begin
                     if (req_last) begin
                        cmd.op   = wep_pkg::OP_SEED_LAST;
                        state_in = ST_FILL;
                     end else begin
                        cmd.op = wep_pkg::OP_SEED;
                     end
                  end
                  wep_pkg::CMD_DATA, wep_pkg::CMD_ICV: begin
                     cmd.op   = wep_pkg::OP_BYTE_START;
                     state_in = ST_PRJ;
                  end
                  default: cmd.op = wep_pkg::OP_IDLE;
               endcase
            end
         end
         ST_FILL: begin
            cmd.op = wep_pkg::OP_FILL;
            if (status.cnt_max) state_in = ST_KRA;
         end
         ST_KRA: begin
            cmd.op   = wep_pkg::OP_KSA_RD_A;
            state_in = ST_KRB;
         end
         ST_KRB: begin
            cmd.op   = wep_pkg::OP_KSA_RD_B;
            state_in = ST_KWA;
         end
         ST_KWA: begin
            cmd.op   = wep_pkg::OP_KSA_WR_A;
            state_in = ST_KWB;
         end
         ST_KWB: begin
            cmd.op   = wep_pkg::OP_KSA_WR_B;
            state_in = status.cnt_max ? ST_IDLE : ST_KRA;
         end
         ST_PRJ: begin
            cmd.op   = wep_pkg::OP_PRGA_RD_J;
            state_in = ST_PRT;
         end
         ST_PRT: begin
            cmd.op   = wep_pkg::OP_PRGA_RD_T;
            state_in = ST_PFIN;
         end
         ST_PFIN: begin
            // Hold here until the result register is free.
            if (status.out_free) begin
               cmd.op   = wep_pkg::OP_PRGA_FIN;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/wep_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wep_dp
// Datapath: RC4 permutation memory, seed store, indices, CRC-32 accumulator,
// integrity check bookkeeping and the result register.
// ----------------------------------------------------------------------------
module wep_dp (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire wep_pkg::ctl_cmd_type   cmd,
   input  wire logic [1:0]             req_command,
   input  wire logic [7:0]             req_value,
   input  wire logic                   req_last,
   output wep_pkg::dp_status_type      status,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic                        rsp_result_kind,
   output logic [7:0]                  rsp_plain_byte,
   output logic                        rsp_icv_ok
);

   // Permutation memory and its single read port.
   logic [7:0] perm_mem [256];
   logic [7:0] rd_data_ff;
   logic       rd_en;
   logic [7:0] rd_addr;
   logic       wr_en;
   logic [7:0] wr_addr;
   logic [7:0] wr_data;

   // Seed store.
   logic [7:0]                      seed_mem [wep_pkg::SEED_BYTES];
   logic [7:0]                      seed_rd_ff;
   logic [wep_pkg::SEED_CNT_W-1:0]  seed_count_ff, seed_count_in;
   logic [wep_pkg::SEED_AW-1:0]     kidx_ff, kidx_in;

   // Indices and scratch registers.
   logic [7:0]  i_ff, i_in;
   logic [7:0]  j_ff, j_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [7:0]  sa_ff, sa_in;
   logic [7:0]  sb_ff, sb_in;
   logic [7:0]  t_ff, t_in;
   logic [7:0]  val_ff, val_in;
   logic        icv_ff, icv_in;
   logic        last_ff, last_in;

   // Frame checks.
   logic [31:0] crc_ff, crc_in;
   logic [2:0]  icv_count_ff, icv_count_in;
   logic        mismatch_ff, mismatch_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_ok_ff, rsp_ok_in;

   // Helpers.
   logic [7:0]  key_byte;
   logic [7:0]  plain;
   logic [31:0] crc_final;
   logic [7:0]  expect_byte;
   logic        mismatch_next;
   logic [2:0]  icv_count_next;
   logic [7:0]  ksa_b;
   logic        seed_room;

   assign status.cnt_max  = (cnt_ff == 8'hFF);
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_plain_byte  = rsp_byte_ff;
   assign rsp_icv_ok      = rsp_ok_ff;

   assign seed_room = (seed_count_ff < wep_pkg::SEED_CNT_W'(wep_pkg::SEED_BYTES));
   assign ksa_b     = j_ff + rd_data_ff + seed_rd_ff;

   // Keystream byte, with bypass for the swap written in the same cycle.
   always_comb begin
      if (t_ff == i_ff) begin
         key_byte = sb_ff;
      end else if (t_ff == j_ff) begin
         key_byte = sa_ff;
      end else begin
         key_byte = rd_data_ff;
      end
   end

   assign plain       = val_ff ^ key_byte;
   assign crc_final   = ~crc_ff;
   assign expect_byte = crc_final[{icv_count_ff[1:0], 3'b000} +: 8];

   always_comb begin
      mismatch_next  = mismatch_ff;
      icv_count_next = icv_count_ff;
      if (icv_count_ff < wep_pkg::ICV_LEN) begin
         if (plain != expect_byte) mismatch_next = 1'b1;
      end else begin
         mismatch_next = 1'b1;
      end
      if (icv_count_ff < wep_pkg::ICV_LEN + 3'd1) icv_count_next = icv_count_ff + 3'd1;
   end

   // Operation decode.
   always_comb begin
      rd_en         = 1'b0;
      rd_addr       = i_ff + 8'd1;
      wr_en         = 1'b0;
      wr_addr       = cnt_ff;
      wr_data       = cnt_ff;
      seed_count_in = seed_count_ff;
      kidx_in       = kidx_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      cnt_in        = cnt_ff;
      sa_in         = sa_ff;
      sb_in         = sb_ff;
      t_in          = t_ff;
      val_in        = val_ff;
      icv_in        = icv_ff;
      last_in       = last_ff;
      crc_in        = crc_ff;
      icv_count_in  = icv_count_ff;
      mismatch_in   = mismatch_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_ok_in     = rsp_ok_ff;
      unique case (cmd.op)
         wep_pkg::OP_NONE: begin
         end
         wep_pkg::OP_IDLE: begin
            rd_en = 1'b1;
         end
         wep_pkg::OP_SEED, wep_pkg::OP_SEED_LAST: begin
            if (seed_room) seed_count_in = seed_count_ff + wep_pkg::SEED_CNT_W'(1);
            if (cmd.op == wep_pkg::OP_SEED_LAST) begin
               cnt_in  = 8'd0;
               j_in    = 8'd0;
               kidx_in = '0;
            end
         end
         wep_pkg::OP_FILL: begin
            wr_en  = 1'b1;
            cnt_in = cnt_ff + 8'd1;
         end
         wep_pkg::OP_KSA_RD_A: begin
            rd_en   = 1'b1;
            rd_addr = cnt_ff;
         end
         wep_pkg::OP_KSA_RD_B: begin
            sa_in   = rd_data_ff;
            j_in    = ksa_b;
            rd_en   = 1'b1;
            rd_addr = ksa_b;
         end
         wep_pkg::OP_KSA_WR_A: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = rd_data_ff;
         end
         wep_pkg::OP_KSA_WR_B: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = sa_ff;
            cnt_in  = cnt_ff + 8'd1;
            if ({1'b0, kidx_ff} + wep_pkg::SEED_CNT_W'(1) == seed_count_ff) begin
               kidx_in = '0;
            end else begin
               kidx_in = kidx_ff + wep_pkg::SEED_AW'(1);
            end
            // End of the key schedule: fresh indices and frame checks.
            if (cnt_ff == 8'hFF) begin
               i_in          = 8'd0;
               j_in          = 8'd0;
               seed_count_in = '0;
               crc_in        = wep_pkg::CRC_PRESET;
               icv_count_in  = 3'd0;
               mismatch_in   = 1'b0;
            end
         end
         wep_pkg::OP_BYTE_START: begin
            rd_en   = 1'b1;
            i_in    = i_ff + 8'd1;
            val_in  = req_value;
            icv_in  = (req_command == wep_pkg::CMD_ICV);
            last_in = req_last;
         end
         wep_pkg::OP_PRGA_RD_J: begin
            sa_in   = rd_data_ff;
            j_in    = j_ff + rd_data_ff;
            rd_en   = 1'b1;
            rd_addr = j_ff + rd_data_ff;
         end
         wep_pkg::OP_PRGA_RD_T: begin
            wr_en   = 1'b1;
            wr_addr = i_ff;
            wr_data = rd_data_ff;
            sb_in   = rd_data_ff;
            t_in    = sa_ff + rd_data_ff;
            rd_en   = 1'b1;
            rd_addr = sa_ff + rd_data_ff;
         end
         wep_pkg::OP_PRGA_FIN: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = sa_ff;
            if (!icv_ff) begin
               crc_in       = wep_pkg::crc_byte(crc_ff, plain);
               rsp_valid_in = 1'b1;
               rsp_kind_in  = wep_pkg::KIND_PLAIN;
               rsp_byte_in  = plain;
               rsp_ok_in    = 1'b0;
            end else if (last_ff) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = wep_pkg::KIND_VERDICT;
               rsp_byte_in  = 8'd0;
               rsp_ok_in    = !mismatch_next && (icv_count_next == wep_pkg::ICV_LEN);
               crc_in       = wep_pkg::CRC_PRESET;
               icv_count_in = 3'd0;
               mismatch_in  = 1'b0;
            end else begin
               icv_count_in = icv_count_next;
               mismatch_in  = mismatch_next;
            end
         end
         default: begin
         end
      endcase
   end

   // Permutation memory.
   always_ff @(posedge clock) begin
      if (wr_en) perm_mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= perm_mem[rd_addr];
   end

   // Seed store: bytes beyond its depth are dropped. The entry for the
   // current key schedule step is read into a register ahead of its use.
   always_ff @(posedge clock) begin
      if ((cmd.op == wep_pkg::OP_SEED || cmd.op == wep_pkg::OP_SEED_LAST) && seed_room) begin
         seed_mem[seed_count_ff[wep_pkg::SEED_AW-1:0]] <= req_value;
      end
      seed_rd_ff <= seed_mem[kidx_ff];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff          <= 8'd0;
         j_ff          <= 8'd0;
         seed_count_ff <= '0;
         crc_ff        <= wep_pkg::CRC_PRESET;
         icv_count_ff  <= 3'd0;
         mismatch_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         i_ff          <= i_in;
         j_ff          <= j_in;
         seed_count_ff <= seed_count_in;
         crc_ff        <= crc_in;
         icv_count_ff  <= icv_count_in;
         mismatch_ff   <= mismatch_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload and scratch registers.
   always_ff @(posedge clock) begin
      kidx_ff     <= kidx_in;
      cnt_ff      <= cnt_in;
      sa_ff       <= sa_in;
      sb_ff       <= sb_in;
      t_ff        <= t_in;
      val_ff      <= val_in;
      icv_ff      <= icv_in;
      last_ff     <= last_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

endmodule
`default_nettype wire

FILE: hdl/wep_rc4_decrypt_icv_check_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wep_rc4_decrypt_icv_check_top
// WEP frame decryptor: RC4 key schedule and keystream, CRC-32 over the
// plaintext and a check of the four encrypted ICV bytes.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  req_*    in         command, value (tdata), last (tlast)
//  rsp_*    out        plain_byte, icv_ok (tdata), result_kind (tuser)
//
//  A seed byte or an ignored command is taken in the idle state. A data or ICV
//  byte passes the j read, keystream read and finish states: the single read port
//  of the permutation memory serves the reads at i, j and the keystream index in
//  turn, with the swap written alongside. The final seed byte starts the fill of
//  all 256 entries and 256 key schedule steps before the next item is taken.
//  Reset is synchronous; a stalled result holds the next byte in its last cycle.
// ----------------------------------------------------------------------------
module wep_rc4_decrypt_icv_check_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [1:0] command, [9:2] value, zero fill
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] plain_byte, [8] icv_ok, zero fill
   output logic             rsp_tuser    // [0] result_kind
);

   wep_pkg::ctl_cmd_type   cmd;
   wep_pkg::dp_status_type status;
   logic [7:0]             plain_byte;
   logic                   icv_ok;

   // Controller.
   wep_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_command (req_tdata[1:0]),
      .req_last    (req_tlast),
      .req_tready  (req_tready),
      .status      (status),
      .cmd         (cmd)
   );

   // Datapath.
   wep_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_command     (req_tdata[1:0]),
      .req_value       (req_tdata[9:2]),
      .req_last        (req_tlast),
      .status          (status),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_result_kind (rsp_tuser),
      .rsp_plain_byte  (plain_byte),
      .rsp_icv_ok      (icv_ok)
   );

   assign rsp_tdata = {7'd0, icv_ok, plain_byte};

endmodule
`default_nettype wire

FILE: bench/wep_rc4_decrypt_icv_check_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wep_rc4_decrypt_icv_check_top_tb
// Self-checking bench for the WEP frame decryptor. Frames of seed, ciphertext
// and ICV bytes are streamed in with random bursts and gaps, while the result
// side stalls on its own pattern. A software copy of the RC4 keystream and
// the CRC-32 predicts every plaintext byte and verdict, and each result
// transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module wep_rc4_decrypt_icv_check_top_tb;

   // Command code that the block ignores.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int ITEM_TARGET = 1500;
   localparam int LONG_HOLD   = 400;
   localparam int QUIET_LIMIT = 10000;
   localparam int TAIL_CYCLES = 12;

   typedef struct packed {
      logic       kind;
      logic [7:0] plain;
      logic       ok;
   } decrypt_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [1:0] command, [9:2] value, zero fill
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [7:0] plain_byte, [8] icv_ok, zero fill
   logic        rsp_tuser;   // [0] result_kind

   // Predicted results still waiting for their transfer.
   decrypt_result_type decrypted_q[$];

   // Shadow copy of the decryptor state.
   logic [7:0]  sbox [256];
   logic [7:0]  ks_i;
   logic [7:0]  ks_j;
   logic [31:0] crc_acc;
   logic [7:0]  seed_mem [wep_pkg::SEED_BYTES];
   int          seed_n;
   int          icv_n;
   bit          icv_bad;
   bit          keyed;

   int          error_count;
   int          items_sent;
   int          burst_left;
   bit          hold_request;

   wep_rc4_decrypt_icv_check_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Reflected CRC-32 over one byte, least significant bit first.
   function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      repeat (8) r = (r >> 1) ^ (r[0] ? wep_pkg::CRC_POLY : 32'd0);
      return r;
   endfunction

   function automatic void clear_frame();
      crc_acc = wep_pkg::CRC_PRESET;
      icv_n   = 0;
      icv_bad = 1'b0;
   endfunction

   // RC4 key schedule over the bytes held so far; the first SEED_BYTES only.
   function automatic void run_key_schedule();
      int         n;
      logic [7:0] b;
      logic [7:0] t;
      n = (seed_n == 0) ? 1 : seed_n;
      b = 8'd0;
      for (int a = 0; a < 256; a++) sbox[a] = a[7:0];
      for (int a = 0; a < 256; a++) begin
         b       = b + sbox[a] + seed_mem[a % n];
         t       = sbox[a];
         sbox[a] = sbox[b];
         sbox[b] = t;
      end
      ks_i   = 8'd0;
      ks_j   = 8'd0;
      seed_n = 0;
      keyed  = 1'b1;
      clear_frame();
   endfunction

   // One keystream byte, advancing the indices and swapping.
   function automatic logic [7:0] next_keystream();
      logic [7:0] t;
      logic [7:0] k;
      ks_i       = ks_i + 8'd1;
      ks_j       = ks_j + sbox[ks_i];
      t          = sbox[ks_i];
      sbox[ks_i] = sbox[ks_j];
      sbox[ks_j] = t;
      k          = sbox[ks_i] + sbox[ks_j];
      return sbox[k];
   endfunction

   // The keystream byte that the next data or ICV byte will use, without
   // touching the state. The swap is folded into the final lookup.
   function automatic logic [7:0] peek_keystream();
      logic [7:0] ni;
      logic [7:0] nj;
      logic [7:0] k;
      ni = ks_i + 8'd1;
      nj = ks_j + sbox[ni];
      k  = sbox[ni] + sbox[nj];
      if (k == ni) return sbox[nj];
      if (k == nj) return sbox[ni];
      return sbox[k];
   endfunction

   // Applies one accepted item to the shadow state and queues its result.
   task automatic predict_decrypt(input logic [1:0] cmd, input logic [7:0] val,
                                  input logic last);
      decrypt_result_type r;
      logic [7:0]         p;
      logic [31:0]        fin;
      case (cmd)
         wep_pkg::CMD_SEED: begin
            if (seed_n < wep_pkg::SEED_BYTES) begin
               seed_mem[seed_n] = val;
               seed_n++;
            end
            if (last) run_key_schedule();
         end
         wep_pkg::CMD_DATA: begin
            p       = val ^ next_keystream();
            crc_acc = crc_update(crc_acc, p);
            r.kind  = wep_pkg::KIND_PLAIN;
            r.plain = p;
            r.ok    = 1'b0;
            decrypted_q.push_back(r);
         end
         wep_pkg::CMD_ICV: begin
            p   = val ^ next_keystream();
            fin = ~crc_acc;
            if (icv_n < wep_pkg::ICV_LEN) begin
               if (p != fin[8*icv_n +: 8]) icv_bad = 1'b1;
            end else begin
               icv_bad = 1'b1;
            end
            // The count saturates one past a full ICV.
            if (icv_n <= wep_pkg::ICV_LEN) icv_n++;
            if (last) begin
               r.kind  = wep_pkg::KIND_VERDICT;
               r.plain = 8'd0;
               r.ok    = !icv_bad && (icv_n == wep_pkg::ICV_LEN);
               decrypted_q.push_back(r);
               clear_frame();
            end
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Sending side
   // ------------------------------------------------------------------------

   // Offers one item and holds it until the transfer, with bursts and gaps.
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] val,
                            input logic last);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, val, cmd};
      req_tlast  <= last;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      burst_left--;
      if (cmd != CMD_UNUSED) items_sent++;
      predict_decrypt(cmd, val, last);
   endtask

   // A seed of the given length with last on its final byte.
   task automatic send_seed(input int len);
      for (int k = 0; k < len; k++)
         send_item(wep_pkg::CMD_SEED, $urandom_range(0, 255), k == len - 1);
   endtask

   // One encrypted ICV byte, correct for the current CRC unless told otherwise.
   task automatic send_icv(input bit good, input bit last);
      logic [7:0]  want;
      logic [7:0]  v;
      logic [31:0] fin;
      fin  = ~crc_acc;
      want = (icv_n < wep_pkg::ICV_LEN) ? fin[8*icv_n +: 8] : $urandom_range(0, 255);
      v    = want ^ peek_keystream();
      if (!good) v = v ^ (8'd1 << $urandom_range(0, 7));
      send_item(wep_pkg::CMD_ICV, v, last);
   endtask

   // A run of ICV bytes with last on the final one; bad_at marks a corrupt one.
   task automatic send_icv_run(input int n, input int bad_at);
      for (int k = 0; k < n; k++) send_icv(k != bad_at, k == n - 1);
   endtask

   // A data byte slipped in between the ICV bytes; the verdict still passes.
   task automatic send_split_icv_frame();
      send_icv(1'b1, 1'b0);
      send_item(wep_pkg::CMD_DATA, $urandom_range(0, 255), 1'b0);
      send_icv(1'b1, 1'b0);
      send_icv(1'b1, 1'b0);
      send_icv(1'b1, 1'b1);
   endtask

   // Stops offering and waits for every predicted result.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (decrypted_q.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Seventeen seed bytes, so the last one is dropped, with an ignored
   // command in the middle; the extremes of the byte open the seed.
   task automatic test_seed_overflow();
      logic [7:0] v;
      for (int k = 0; k <= wep_pkg::SEED_BYTES; k++) begin
         if (k == wep_pkg::SEED_BYTES / 2) send_item(CMD_UNUSED, 8'hFF, 1'b1);
         v = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : $urandom_range(0, 255);
         send_item(wep_pkg::CMD_SEED, v, k == wep_pkg::SEED_BYTES);
      end
   endtask

   // Ciphertext extremes followed by a correct ICV.
   task automatic test_good_frame();
      send_item(wep_pkg::CMD_DATA, 8'h00, 1'b0);
      send_item(wep_pkg::CMD_DATA, 8'hFF, 1'b0);
      send_icv_run(4, -1);
   endtask

   // A verdict after a single ICV byte, then one after five.
   task automatic test_icv_count();
      send_icv_run(1, -1);
      send_icv_run(5, -1);
   endtask

   task automatic test_data_among_icv();
      send_split_icv_frame();
   endtask

   // The receiver holds off for a long stretch while data keeps coming.
   task automatic test_receiver_hold();
      hold_request = 1'b1;
      repeat (32) send_item(wep_pkg::CMD_DATA, $urandom_range(0, 255), 1'b0);
      send_icv_run(4, -1);
   endtask

   // The sender pauses until every result is back, then continues the stream.
   task automatic test_sender_pause();
      send_seed(wep_pkg::SEED_BYTES);
      repeat (6) send_item(wep_pkg::CMD_DATA, $urandom_range(0, 255), 1'b0);
      send_icv_run(4, -1);
      wait_for_results();
      repeat (3) send_item(wep_pkg::CMD_DATA, $urandom_range(0, 255), 1'b0);
      send_icv_run(4, -1);
   endtask

   // Mostly well-formed frames with random content; the rest are corrupt
   // ICVs, wrong ICV counts, split ICVs and stray items.
   task automatic test_random();
      int shape;
      int nbytes;
      while (items_sent < ITEM_TARGET) begin
         shape = $urandom_range(0, 19);
         if (!keyed || $urandom_range(0, 2) == 0)
            send_seed(($urandom_range(0, 9) == 0)
                      ? $urandom_range(wep_pkg::SEED_BYTES + 1, 24)
                      : $urandom_range(1, wep_pkg::SEED_BYTES));
         nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
         repeat (nbytes) send_item(wep_pkg::CMD_DATA, $urandom_range(0, 255), 1'b0);
         if (shape < 14) begin
            send_icv_run(4, -1);
         end else if (shape < 16) begin
            send_icv_run(4, $urandom_range(0, 3));
         end else if (shape < 18) begin
            send_icv_run($urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(5, 7), -1);
         end else if (shape == 18) begin
            send_split_icv_frame();
         end else begin
            // Stray items: ignored commands, at times a seed byte without last, and
            // an ICV byte without last; the seed and ICV bytes carry into the next frame.
            repeat ($urandom_range(1, 3))
               send_item(CMD_UNUSED, $urandom_range(0, 255), $urandom_range(0, 1));
            if ($urandom_range(0, 1))
               send_item(wep_pkg::CMD_SEED, $urandom_range(0, 255), 1'b0);
            send_icv($urandom_range(0, 1), 1'b0);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Result checking and receiver stalls
   // ------------------------------------------------------------------------

   task automatic check_result();
      decrypt_result_type want;
      if (decrypted_q.size() == 0) begin
         $display("%0t: result with nothing predicted: kind %0d byte %02h icv_ok %0d",
                  $time, rsp_tuser, rsp_tdata[7:0], rsp_tdata[8]);
         error_count++;
      end else begin
         want = decrypted_q.pop_front();
         if (rsp_tuser !== want.kind) begin
            $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, rsp_tuser);
            error_count++;
         end
         if (rsp_tdata[7:0] !== want.plain) begin
            $display("%0t: plain_byte expected %02h actual %02h",
                     $time, want.plain, rsp_tdata[7:0]);
            error_count++;
         end
         if (rsp_tdata[8] !== want.ok) begin
            $display("%0t: icv_ok expected %0d actual %0d", $time, want.ok, rsp_tdata[8]);
            error_count++;
         end
      end
   endtask

   // Checks each result transfer and picks the next ready value. The stall
   // pattern switches among random modes; a long hold-off is counted here once
   // requested.
   initial begin : receiver
      int   mode;
      int   mode_left;
      int   hold_left;
      logic ready_next;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) check_result();
         if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         if (reset || hold_left > 0) begin
            ready_next = 1'b0;
         end else begin
            case (mode)
               0:       ready_next = 1'b1;
               1:       ready_next = ($urandom_range(0, 3) != 0);
               2:       ready_next = ($urandom_range(0, 3) == 0);
               default: ready_next = !rsp_tready;
            endcase
         end
         if (hold_left > 0) hold_left--;
         rsp_tready <= ready_next;
      end
   end

   // Ends the run when no transfer has happened on either side for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset === 1'b1 || (req_tvalid === 1'b1 && req_tready === 1'b1) ||
             (rsp_tvalid === 1'b1 && rsp_tready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: watchdog expired after %0d cycles without a transfer", $time, QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin : main_sequence
      error_count  = 0;
      items_sent   = 0;
      burst_left   = 0;
      hold_request = 1'b0;
      seed_n       = 0;
      ks_i         = 8'd0;
      ks_j         = 8'd0;
      keyed        = 1'b0;
      clear_frame();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 16'd0;
      req_tlast  <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_seed_overflow();
      test_good_frame();
      test_icv_count();
      test_data_among_icv();
      test_receiver_hold();
      test_sender_pause();
      test_random();

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: sim.f
hdl/wep_pkg.sv
hdl/wep_ctrl.sv
hdl/wep_dp.sv
hdl/wep_rc4_decrypt_icv_check_top.sv
bench/wep_rc4_decrypt_icv_check_top_tb.sv
